/* design/sarlc_pkg.sv */
// Shared types, codes and constants for the set-associative refcount LRU cache.
package sarlc_pkg;

    localparam int unsigned WAYS_DEF = 8;
    localparam int unsigned SETS_DEF = 64;
    localparam int unsigned IDX_W    = 32;
    localparam int unsigned CFG_W    = 32;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_DEREF  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_HIT        = 4'd0,
        ST_MISS       = 4'd1,
        ST_STORED     = 4'd2,
        ST_NOT_CACHED = 4'd3,
        ST_RELEASED   = 4'd4,
        ST_NOT_FOUND  = 4'd5,
        ST_BAD_INDEX  = 4'd6,
        ST_SET_UNINIT = 4'd7,
        ST_MISMATCH   = 4'd8
    } t_status;

    typedef enum logic {
        REG_SETS_IN_USE = 1'b0,
        REG_TRACE_COUNT = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SET,
        S_READ,
        S_WAIT,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_WRITE,
        S_DONE,
        S_CLEAR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture command, start divider
        logic div_step;   // one quotient bit
        logic set_latch;  // latch set number, read set_ready
        logic rd_issue;   // read way at scan counter
        logic scan;       // absorb read data of one way
        logic decide;     // form result and plan the update
        logic wr_way;     // write one way back
        logic finish;     // present the result
        logic clr;        // clearing pass step
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic last_way;
        logic rd_needed;  // set is initialized and the index is in range
        logic wr_needed;  // an update must be written
        logic drop;       // no result for this command
        logic clr_done;
    } t_sts;

endpackage

/* design/sarlc_ctrl.sv */
// Controller state machine: clear pass, divide, set read, way scan, write back.
module sarlc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sarlc_pkg::t_sts    i_sts,
    output sarlc_pkg::t_ctl    o_ctl,
    output logic               o_busy
);
    import sarlc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.drop) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctl.div_step = 1'b1;
                    if (i_sts.div_done) n_state = S_SET;
                end
            end
            S_SET: begin
                o_ctl.set_latch = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_sts.rd_needed) begin
                    o_ctl.rd_issue = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_SCAN: begin
                o_ctl.scan     = 1'b1;
                o_ctl.rd_issue = 1'b1;
                if (i_sts.last_way) n_state = S_LAST;
            end
            S_LAST: begin
                // absorb the last way read
                o_ctl.scan = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_ctl.decide = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = i_sts.wr_needed ? S_WRITE : S_DONE;
            end
            S_WRITE: begin
                o_ctl.wr_way = 1'b1;
                if (i_sts.last_way) n_state = S_DONE;
            end
            S_DONE: begin
                o_ctl.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ctl.finish && o_busy)
        else $error("result during clearing pass");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> !o_busy)
        else $error("not idle after result");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> !o_busy && (r_state == S_IDLE))
        else $error("load outside idle");

endmodule

/* design/sarlc_dpath.sv */
// Datapath: divider, set_ready bits, way memories, scan, victim choice and write back.
module sarlc_dpath #(
    parameter int unsigned WAYS = sarlc_pkg::WAYS_DEF,
    parameter int unsigned SETS = sarlc_pkg::SETS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sarlc_pkg::t_ctl      i_ctl,
    output sarlc_pkg::t_sts      o_sts,
    input  logic [1:0]           i_cmd,
    input  logic [31:0]          i_item_index,
    input  logic [31:0]          i_handle,
    input  logic [6:0]           i_sets_in_use,
    input  logic [31:0]          i_trace_count,
    output logic                 o_valid,
    output logic [3:0]           o_status,
    output logic [31:0]          o_hit_handle,
    output logic [2:0]           o_way_used,
    output logic                 o_evicted,
    output logic [31:0]          o_evicted_handle,
    output logic                 o_free_input,
    output logic [31:0]          o_hit_total,
    output logic [31:0]          o_miss_total
);
    import sarlc_pkg::*;

    localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned SW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned DEP = SETS * WAYS;
    localparam int unsigned AW  = (DEP > 1) ? $clog2(DEP) : 1;
    localparam int unsigned CW  = $clog2(SETS + 1);   // width of active set count
    localparam int unsigned KW  = $clog2(IDX_W + 1);

    // entry word: valid, age, refs, tag, handle
    typedef struct packed {
        logic        vld;
        logic [7:0]  age;
        logic [7:0]  refs;
        logic [31:0] tag;
        logic [31:0] hnd;
    } t_ent;

    // command capture
    logic [1:0]  r_cmd;
    logic [31:0] r_idx, r_hnd;
    logic        r_bad;
    logic [CW-1:0] r_div;

    // restoring divider for idx % active_sets
    logic [CW:0]   r_rem;
    logic [KW-1:0] r_k;
    logic [CW:0]   w_shift;
    logic [CW-1:0] w_act;

    always_comb begin
        if (i_sets_in_use == 7'd0) w_act = CW'(1);
        else if (32'(i_sets_in_use) > SETS) w_act = CW'(SETS);
        else w_act = CW'(i_sets_in_use);
    end

    assign w_shift = {r_rem[CW-1:0], r_idx[31]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_idx <= i_item_index;
            r_hnd <= i_handle;
            r_bad <= (i_item_index >= i_trace_count);
            r_div <= w_act;
            r_rem <= '0;
            r_k   <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= (w_shift >= {1'b0, r_div}) ? w_shift - {1'b0, r_div} : w_shift;
            r_idx <= {r_idx[30:0], r_idx[31]};  // rotate so the index returns intact
            r_k   <= r_k + KW'(1);
        end
    end

    // set_ready flags, cleared at once by reset
    logic [SETS-1:0] r_ready;
    logic [SW-1:0]   r_set;
    logic            r_set_rdy;

    // way memory, cleared by sweep after reset
    t_ent r_mem [DEP];
    t_ent r_rd;
    logic [AW-1:0] r_clr;
    logic          r_clr_done;

    logic [WW-1:0] r_way;       // scan / write counter
    logic [WW-1:0] r_wway;      // way being read
    logic          r_rd_v;

    // per-way copies for the chosen set
    t_ent r_ways [WAYS];

    // decision
    logic          r_wr;
    logic [3:0]    r_st;
    logic [31:0]   r_hh, r_eh;
    logic [WW-1:0] r_wu;
    logic          r_ev, r_fi;
    logic [31:0]   r_hits, r_miss;

    logic [AW-1:0] w_base_rd, w_base_wr;
    assign w_base_rd = AW'(r_set) * AW'(WAYS) + AW'(r_way);

    // scan results
    logic          w_any_hit;
    logic [WW-1:0] w_hit_w;
    logic          w_have_inv, w_have_free;
    logic [WW-1:0] w_inv_w, w_free_w;
    logic [7:0]    w_inv_a, w_free_a;

    always_comb begin
        w_any_hit = 1'b0; w_hit_w = '0;
        w_have_inv = 1'b0; w_inv_w = '0; w_inv_a = '0;
        w_have_free = 1'b0; w_free_w = '0; w_free_a = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!w_any_hit && r_ways[i].vld && r_ways[i].tag == r_idx) begin
                w_any_hit = 1'b1; w_hit_w = WW'(i);
            end
            if (!r_ways[i].vld && (!w_have_inv || r_ways[i].age > w_inv_a)) begin
                w_have_inv = 1'b1; w_inv_w = WW'(i); w_inv_a = r_ways[i].age;
            end
            if (r_ways[i].refs == 8'd0 && (!w_have_free || r_ways[i].age > w_free_a)) begin
                w_have_free = 1'b1; w_free_w = WW'(i); w_free_a = r_ways[i].age;
            end
        end
    end

    // target way and action, planned at decide
    logic [WW-1:0] r_tgt;
    logic          r_act_hit, r_act_store, r_act_rel;
    logic [7:0]    r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= '0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_hits     <= '0;
            r_miss     <= '0;
            o_valid    <= 1'b0;
            r_rd_v     <= 1'b0;
        end else begin
            o_valid <= i_ctl.finish;
            r_rd_v  <= i_ctl.rd_issue;
            if (i_ctl.clr) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(DEP - 1)) r_clr_done <= 1'b1;
            end
            if (i_ctl.decide && !r_bad) begin
                if (r_cmd == CMD_LOOKUP) begin
                    if (r_set_rdy && w_any_hit) begin
                        if (r_hits != '1) r_hits <= r_hits + 32'd1;
                    end else if (r_miss != '1) begin
                        r_miss <= r_miss + 32'd1;
                    end
                end
                if (r_cmd != CMD_DEREF) r_ready[r_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set_latch) begin
            r_set     <= SW'(r_rem);
            r_set_rdy <= r_ready[SW'(r_rem)];
            r_way     <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_ways[i].vld  <= 1'b0;
                r_ways[i].refs <= 8'd0;
                r_ways[i].age  <= 8'(WAYS - 1 - i);
                r_ways[i].tag  <= '0;
                r_ways[i].hnd  <= '0;
            end
        end
        if (i_ctl.rd_issue) begin
            r_rd   <= r_mem[w_base_rd];
            r_wway <= r_way;
            r_way  <= r_way + WW'(1);
        end
        if (i_ctl.scan && r_rd_v) r_ways[r_wway] <= r_rd;
        if (i_ctl.decide) begin
            r_way <= '0;
            r_st  <= ST_BAD_INDEX;
            r_hh  <= '0; r_eh <= '0; r_wu <= '0; r_ev <= 1'b0; r_fi <= 1'b0;
            r_act_hit <= 1'b0; r_act_store <= 1'b0; r_act_rel <= 1'b0;
            r_wr   <= 1'b0;
            r_tgt  <= '0;
            r_limit <= '0;
            if (!r_bad) begin
                unique case (r_cmd)
                    CMD_LOOKUP: begin
                        r_wr <= !r_set_rdy || w_any_hit;
                        if (r_set_rdy && w_any_hit) begin
                            r_st <= ST_HIT; r_hh <= r_ways[w_hit_w].hnd;
                            r_wu <= w_hit_w; r_act_hit <= 1'b1; r_tgt <= w_hit_w;
                            r_limit <= r_ways[w_hit_w].age;
                        end else begin
                            r_st <= ST_MISS;
                        end
                    end
                    CMD_STORE: begin
                        if (w_have_inv || w_have_free) begin
                            r_wr <= 1'b1;
                            r_st <= ST_STORED; r_act_store <= 1'b1;
                            r_tgt <= w_have_inv ? w_inv_w : w_free_w;
                            r_wu  <= w_have_inv ? w_inv_w : w_free_w;
                            if (!w_have_inv) begin
                                r_ev <= r_ways[w_free_w].vld;
                                r_eh <= r_ways[w_free_w].vld ? r_ways[w_free_w].hnd : '0;
                            end
                        end else begin
                            r_wr <= !r_set_rdy;
                            r_st <= ST_NOT_CACHED; r_fi <= 1'b1;
                        end
                    end
                    CMD_DEREF: begin
                        if (!r_set_rdy) begin
                            r_st <= ST_SET_UNINIT; r_fi <= 1'b1;
                        end else if (!w_any_hit) begin
                            r_st <= ST_NOT_FOUND; r_fi <= 1'b1;
                        end else begin
                            r_wu <= w_hit_w; r_tgt <= w_hit_w;
                            if (r_ways[w_hit_w].hnd == r_hnd) begin
                                r_st <= ST_RELEASED; r_act_rel <= 1'b1; r_wr <= 1'b1;
                            end else begin
                                r_st <= ST_MISMATCH; r_fi <= 1'b1;
                            end
                        end
                    end
                    default: r_st <= ST_BAD_INDEX;
                endcase
            end
        end
        if (i_ctl.wr_way) r_way <= r_way + WW'(1);
    end

    // updated entry for the way under write back
    t_ent w_new, w_cur;
    always_comb begin
        w_cur = r_ways[r_way];
        w_new = w_cur;
        if (r_act_hit || r_act_store) begin
            if (r_way == r_tgt) begin
                w_new.age = 8'd0;
            end else if (w_cur.age != 8'hFF && (r_act_store || w_cur.age < r_limit)) begin
                w_new.age = w_cur.age + 8'd1;
            end
        end
        if (r_way == r_tgt) begin
            if (r_act_hit && w_cur.refs != 8'hFF) w_new.refs = w_cur.refs + 8'd1;
            if (r_act_rel && w_cur.refs != 8'h00) w_new.refs = w_cur.refs - 8'd1;
            if (r_act_store) begin
                w_new.vld = 1'b1; w_new.tag = r_idx; w_new.hnd = r_hnd; w_new.refs = 8'd1;
            end
        end
    end

    assign w_base_wr = AW'(r_set) * AW'(WAYS) + AW'(r_way);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) r_mem[r_clr] <= '0;
        else if (i_ctl.wr_way) r_mem[w_base_wr] <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            o_status         <= r_st;
            o_hit_handle     <= r_hh;
            o_way_used       <= 3'(r_wu);
            o_evicted        <= r_ev;
            o_evicted_handle <= r_eh;
            o_free_input     <= r_fi;
            o_hit_total      <= r_hits;
            o_miss_total     <= r_miss;
        end
    end

    assign o_sts.div_done  = (r_k == KW'(IDX_W - 1));
    assign o_sts.last_way  = (r_way == WW'(WAYS - 1));
    assign o_sts.rd_needed = !r_bad && r_set_rdy;
    assign o_sts.wr_needed = r_wr;
    assign o_sts.drop      = (r_cmd == CMD_NONE);
    assign o_sts.clr_done  = r_clr_done || (i_ctl.clr && r_clr == AW'(DEP - 1));

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.set_latch |-> (r_rem < {1'b0, r_div}))
        else $error("remainder not below divisor");
    a_hit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.decide && !r_bad && r_cmd == CMD_DEREF) |=> $stable(r_hits) && $stable(r_miss))
        else $error("deref changed lookup counters");
    a_bad_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.decide && r_bad) |=> !r_wr)
        else $error("write back on bad index");

endmodule

/* design/set_assoc_refcount_lru_cache_core.sv */
// Top level of the set-associative refcount LRU cache directory.
// Usage:
//   Commands enter on start with i_cmd, i_item_index and i_handle; one is
//   taken at a clock edge where start is high and busy is low.
//   Every command except code 3 gives one result on the o_ ports, shown for
//   exactly one cycle with o_valid high. Code 3 gives nothing.
//   Registers are written on the config channel (i_cfg_valid/o_cfg_ready,
//   index 0 sets_in_use, index 1 trace_count) while no command is in flight.
// Sequence:
//   A command runs the remainder divider (one quotient bit per cycle), a
//   set_ready check, a read of an initialized set's ways from the way
//   memory, a decide step that plans the update, a wait step, write back
//   of all WAYS ways when the set changes and a result step. busy drops
//   in the cycle the result shows, so the next command may follow then.
//   A bad index skips the memory work; a code 3 is dropped in the cycle
//   after it is taken, without the divide.
// Reset:
//   Clears the set flags and counters, then a clearing pass sweeps the way
//   memory one entry per cycle (SETS*WAYS entries, 512 by default) while
//   busy stays high. Results cannot be stalled by the receiver.
module set_assoc_refcount_lru_cache_core #(
    parameter int unsigned WAYS = sarlc_pkg::WAYS_DEF,
    parameter int unsigned SETS = sarlc_pkg::SETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_item_index,
    input  logic [31:0] i_handle,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [31:0] o_hit_handle,
    output logic [2:0]  o_way_used,
    output logic        o_evicted,
    output logic [31:0] o_evicted_handle,
    output logic        o_free_input,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total
);
    import sarlc_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic [6:0]  r_sets_in_use;
    logic [31:0] r_trace_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sets_in_use <= 7'(SETS_DEF);
            r_trace_count <= '1;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_SETS_IN_USE: r_sets_in_use <= i_cfg_data[6:0];
                REG_TRACE_COUNT: r_trace_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sarlc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    sarlc_dpath #(.WAYS(WAYS), .SETS(SETS)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_cmd            (i_cmd),
        .i_item_index     (i_item_index),
        .i_handle         (i_handle),
        .i_sets_in_use    (r_sets_in_use),
        .i_trace_count    (r_trace_count),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_hit_handle     (o_hit_handle),
        .o_way_used       (o_way_used),
        .o_evicted        (o_evicted),
        .o_evicted_handle (o_evicted_handle),
        .o_free_input     (o_free_input),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total)
    );

endmodule
